// ----- rtl/gmps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared widths and types for the grid minimum path sum block.
// ----------------------------------------------------------------------------
package gmps_pkg;

    // field widths
    localparam int unsigned CELL_W = 4;
    localparam int unsigned COST_W = 15;
    localparam int unsigned CFG_W  = 11;

    // position flags of a cell within the grid
    typedef struct packed {
        logic top_row;
        logic left_col;
    } t_cell_pos;

endpackage
`default_nettype wire

// ----- rtl/gmps_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmps_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data. Read data holds while no read is requested.
// ----------------------------------------------------------------------------
module gmps_ram #(
    parameter int unsigned WIDTH = 15,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/gmps_cell_add.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmps_cell_add
// Running cost of one cell: picks the cheaper neighbor (left wins a tie)
// and adds the cell cost with saturation.
// ----------------------------------------------------------------------------
module gmps_cell_add (
    input  wire gmps_pkg::t_cell_pos              i_pos,
    input  wire logic [gmps_pkg::CELL_W-1:0]      i_cost,
    input  wire logic [gmps_pkg::COST_W-1:0]      i_up_cost,
    input  wire logic [gmps_pkg::COST_W-1:0]      i_left_cost,
    output logic      [gmps_pkg::COST_W-1:0]      o_cost
);
    import gmps_pkg::*;

    logic [COST_W-1:0] w_base;
    logic [COST_W:0]   w_sum;

    // neighbor select
    always_comb begin
        if (i_pos.top_row) begin
            w_base = i_left_cost;
        end else if (i_pos.left_col) begin
            w_base = i_up_cost;
        end else if (i_up_cost < i_left_cost) begin
            w_base = i_up_cost;
        end else begin
            w_base = i_left_cost;
        end
    end

    // saturating add, start cell counts as zero
    assign w_sum = {1'b0, w_base} + (COST_W + 1)'(i_cost);

    always_comb begin
        if (i_pos.top_row && i_pos.left_col) begin
            o_cost = '0;
        end else if (w_sum[COST_W]) begin
            o_cost = '1;
        end else begin
            o_cost = w_sum[COST_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/grid_min_path_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_min_path_sum
// Minimum right/down path cost through a square grid streamed row by row.
// ----------------------------------------------------------------------------
// Usage:
//   Write the grid side length on the cfg channel while the block is idle;
//   this also restarts the grid. Sides of 0 or above MAX_SIZE are clamped.
//   Stream cell costs on the in channel in row-major order, one request per
//   cell. The cell at the bottom-right corner produces one request on the
//   out channel carrying the minimum path cost (start cell excluded); no
//   other cell produces a result, and the next cell starts a new grid.
//   Throughput is one cell per cycle unless the output stalls: the row store
//   is read at the column of the cell being accepted; the add/compare works
//   on it in the compute stage; the store write and any result load happen
//   as it leaves. When the out receiver stalls, the block keeps taking cells
//   until the next bottom-right cell would need the output register, and
//   then holds o_in_ready low until the pending result is taken.
//   Reset sets the side to 1 and the grid position to the top-left cell.
//   The row store needs no clearing: every entry is written in the top row
//   before any later row reads it.
// ----------------------------------------------------------------------------
module grid_min_path_sum #(
    parameter int unsigned MAX_SIZE = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gmps_pkg::CFG_W-1:0]        i_cfg_grid_size,
    // cell input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [gmps_pkg::CELL_W-1:0]       i_cell_cost,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [gmps_pkg::COST_W-1:0]       o_path_cost
);
    import gmps_pkg::*;

    localparam int unsigned IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic              w_cfg_wr;
    logic              w_in_acc;
    logic              w_s1_go;
    logic [CFG_W-1:0]  w_cfg_dec;
    logic [COST_W-1:0] w_up_cost;
    logic [COST_W-1:0] w_cell_cost;

    logic [IDX_W-1:0]  r_last_idx, n_last_idx;
    logic [IDX_W-1:0]  r_row,      n_row;
    logic [IDX_W-1:0]  r_col,      n_col;
    logic [COST_W-1:0] r_left,     n_left;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_last;
    t_cell_pos         r_s1_pos;
    logic [CELL_W-1:0] r_s1_cost;
    logic [IDX_W-1:0]  r_s1_col;

    logic              r_out_valid, n_out_valid;
    logic [COST_W-1:0] r_path_cost;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign w_s1_go     = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_s1_go;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // clamp the configured side and keep its last index
    assign w_cfg_dec = i_cfg_grid_size - CFG_W'(1);

    always_comb begin
        n_last_idx = r_last_idx;
        if (w_cfg_wr) begin
            if (i_cfg_grid_size == '0) begin
                n_last_idx = '0;
            end else if (32'(i_cfg_grid_size) > 32'(MAX_SIZE)) begin
                n_last_idx = IDX_W'(MAX_SIZE - 1);
            end else begin
                n_last_idx = IDX_W'(w_cfg_dec);
            end
        end
    end

    // grid position counters
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_cfg_wr) begin
            n_row = '0;
            n_col = '0;
        end else if (w_in_acc) begin
            if (r_col == r_last_idx) begin
                n_col = '0;
                if (r_row == r_last_idx) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + IDX_W'(1);
                end
            end else begin
                n_col = r_col + IDX_W'(1);
            end
        end
    end

    // left neighbor cost
    always_comb begin
        n_left = r_left;
        if (w_cfg_wr) begin
            n_left = '0;
        end else if (w_s1_go) begin
            n_left = w_cell_cost;
        end
    end

    // compute stage occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_acc) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_go) begin
            n_s1_valid = 1'b0;
        end
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_go && r_s1_last) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_left      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_last_idx  <= n_last_idx;
            r_row       <= n_row;
            r_col       <= n_col;
            r_left      <= n_left;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register of the compute stage
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cost         <= i_cell_cost;
            r_s1_col          <= r_col;
            r_s1_pos.top_row  <= (r_row == '0);
            r_s1_pos.left_col <= (r_col == '0);
            r_s1_last         <= (r_row == r_last_idx) && (r_col == r_last_idx);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_last) begin
            r_path_cost <= w_cell_cost;
        end
    end

    // row of running costs, read at the column being accepted
    gmps_ram #(
        .WIDTH (COST_W),
        .DEPTH (MAX_SIZE)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_s1_go),
        .i_waddr (r_s1_col),
        .i_wdata (w_cell_cost),
        .i_re    (w_in_acc),
        .i_raddr (r_col),
        .o_rdata (w_up_cost)
    );

    // add and compare for the cell in the stage
    gmps_cell_add u_cell_add (
        .i_pos       (r_s1_pos),
        .i_cost      (r_s1_cost),
        .i_up_cost   (w_up_cost),
        .i_left_cost (r_left),
        .o_cost      (w_cell_cost)
    );

    assign o_out_valid = r_out_valid;
    assign o_path_cost = r_path_cost;

endmodule
`default_nettype wire
